/* rtl/core/pci_bar_size_and_assign_defines.svh */
// ---------------------------------------------------------------------------
// PCI BAR sizing and allocation - assertion macros
// Shared concurrent assertion helpers for the block's checker.
// ---------------------------------------------------------------------------
`ifndef PCI_BAR_SIZE_AND_ASSIGN_DEFINES_SVH
`define PCI_BAR_SIZE_AND_ASSIGN_DEFINES_SVH

// Clocked assertion, held off while reset is active.
`define PBSA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same-cycle implication on the block's own clock and reset.
`define PBSA_ASSERT_IMPL(name, ante, cons, msg) \
  `PBSA_ASSERT(name, clk_i, rst_ni, (ante) |-> (cons), msg)

`endif

/* rtl/core/pbsa_pkg.sv */
// ---------------------------------------------------------------------------
// PCI BAR sizing and allocation - package
// Shared constants and the result status codes.
// ---------------------------------------------------------------------------
package pbsa_pkg;

  // Number of BAR registers in one function.
  localparam int unsigned BAR_COUNT = 6;

  localparam int unsigned IdxW   = 3;
  localparam int unsigned WordW  = 32;
  localparam int unsigned AddrW  = 64;
  localparam int unsigned CountW = 16;
  localparam int unsigned PaddrW = 5;

  typedef enum logic [2:0] {
    ST_ASSIGNED  = 3'd0,
    ST_IO        = 3'd1,
    ST_UNIMPL    = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_MALFORMED = 3'd4
  } status_e;

endpackage

/* rtl/core/pci_bar_size_and_assign.sv */
// ---------------------------------------------------------------------------
// PCI BAR sizing and aligned bump allocation
// Classifies a probed BAR, decodes its size and carves a naturally aligned
// region out of the configured address window.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake                      | beat
//   --------+-----------+--------------------------------+-----------------------
//   in      | in        | in_valid_i / in_stall_o        | one probed BAR
//   out     | out       | out_valid_o / out_stall_i      | one result per BAR
//   cfg     | in        | APB psel/penable/pwrite, 64 b  | window enable/base/size
//
// One beat enters per cycle while in_stall_o is low; a result passes through the
//   input register, decode register and result register.
// The allocation pointer closes its loop in the result stage through one
//   65-bit add and a set of parallel compares, so back-to-back beats never wait.
// Reset clears valids, counters, pointer and window registers; no clearing pass.
// A stall on out backs up stage by stage; in_stall_o rises only once all
//   three stages hold a beat.
//
module pci_bar_size_and_assign
  import pbsa_pkg::*;
#(
  parameter int unsigned BarCount = BAR_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [IdxW-1:0]   bar_index_i,
  input  logic [WordW-1:0]  original_bar_i,
  input  logic [WordW-1:0]  probe_low_i,
  input  logic [WordW-1:0]  probe_high_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [WordW-1:0]  write_low_o,
  output logic [WordW-1:0]  write_high_o,
  output logic [AddrW-1:0]  region_size_o,
  output logic              wide_bar_o,
  output logic [CountW-1:0] assigned_total_o,
  output logic [CountW-1:0] failed_total_o,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [AddrW-1:0]  pwdata,
  output logic [AddrW-1:0]  prdata,
  output logic              pready
);

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_BASE   = 2'd1,
    REG_SIZE   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_MALFORMED,
    CLS_IO,
    CLS_UNIMPL,
    CLS_MEM
  } bar_class_e;

  localparam logic [IdxW-1:0]  BarLimit  = IdxW'(BarCount);
  localparam logic [IdxW-1:0]  LastBar   = IdxW'(BarCount - 1);
  localparam logic [1:0]       Type64    = 2'b10;
  localparam logic [WordW-1:0] LowMask   = 32'hffff_fff0;
  localparam logic [WordW-1:0] OnesWord  = 32'hffff_ffff;
  localparam logic [AddrW:0]   Top32     = 65'h1_0000_0000;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic             enable_q;
  logic [AddrW-1:0] base_q;
  logic [AddrW-1:0] size_q;
  logic [AddrW:0]   limit_q;     // base + size, 65 bits so it never wraps
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PaddrW-1:3]);

  always_comb begin
    case (cfg_idx)
      REG_ENABLE: prdata = {{(AddrW-1){1'b0}}, enable_q};
      REG_BASE:   prdata = base_q;
      REG_SIZE:   prdata = size_q;
      default:    prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Pipeline control: each stage advances when the one after it has room
  // -------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_adv, s2_adv, s1_adv, fire;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s2_adv     = !s2_valid_q || out_adv;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;
  assign fire       = s2_valid_q && out_adv;

  // -------------------------------------------------------------------------
  // Stage 1: input register
  // -------------------------------------------------------------------------
  logic [IdxW-1:0]  s1_idx_q;
  logic [WordW-1:0] s1_bar_q, s1_lo_q, s1_hi_q;

  // -------------------------------------------------------------------------
  // Decode: classify and isolate the lowest set bit of the size mask
  // -------------------------------------------------------------------------
  logic             dec_is64, dec_unimpl;
  logic [WordW-1:0] dec_lomask;
  logic [AddrW-1:0] dec_mask, dec_span, dec_size;
  bar_class_e       dec_cls;

  assign dec_is64   = (s1_bar_q[2:1] == Type64);
  assign dec_lomask = s1_lo_q & LowMask;
  assign dec_mask   = dec_is64 ? {s1_hi_q, dec_lomask} : {OnesWord, dec_lomask};
  assign dec_unimpl = dec_is64 ? (dec_mask == '0) : (dec_lomask == '0);
  // span covers the lowest set bit and everything below it
  assign dec_span   = dec_mask ^ (dec_mask - AddrW'(1));
  assign dec_size   = dec_mask & dec_span;

  always_comb begin
    if (s1_idx_q >= BarLimit) begin
      dec_cls = CLS_MALFORMED;
    end else if (s1_bar_q[0]) begin
      dec_cls = CLS_IO;
    end else if (dec_is64 && (s1_idx_q >= LastBar)) begin
      dec_cls = CLS_MALFORMED;   // wide BAR has no partner register
    end else if (dec_unimpl) begin
      dec_cls = CLS_UNIMPL;
    end else begin
      dec_cls = CLS_MEM;
    end
  end

  // Stage 2: decode register
  bar_class_e       s2_cls_q;
  logic             s2_wide_q;
  logic [WordW-1:0] s2_bar_q;
  logic [AddrW-1:0] s2_size_q, s2_m_q;

  // -------------------------------------------------------------------------
  // Allocation: round the pointer up to the size and find the region end
  // in one add. With ptr split into an aligned part and a remainder, the
  // aligned start is ptr_hi (+size if remainder) and the end adds one more size.
  // -------------------------------------------------------------------------
  logic [AddrW-1:0]  ptr_q, ptr_hi;
  logic              ptr_rem;
  logic [AddrW:0]    step_start, step_end, start65, end65;
  logic              fits;

  assign ptr_rem    = |(ptr_q & s2_m_q);
  assign ptr_hi     = ptr_q & ~s2_m_q;
  assign step_start = ptr_rem ? {1'b0, s2_size_q} : '0;
  assign step_end   = ptr_rem ? {s2_size_q, 1'b0} : {1'b0, s2_size_q};
  assign start65    = {1'b0, ptr_hi} + step_start;
  assign end65      = {1'b0, ptr_hi} + step_end;

  // Drop anything that reaches the top of the address space, ends below the
  // window, runs past the window or, for a 32-bit BAR, above 4 GiB.
  assign fits = !end65[AddrW] && (end65[AddrW-1:0] >= base_q) && (end65 <= limit_q)
                && (s2_wide_q || (end65 <= Top32));

  status_e          res_status;
  logic [WordW-1:0] res_low, res_high;
  logic [AddrW-1:0] res_size;
  logic             res_wide, res_bump, res_ok, res_fail;

  always_comb begin
    res_status = ST_MALFORMED;
    res_low    = s2_bar_q;
    res_high   = '0;
    res_size   = '0;
    res_wide   = 1'b0;
    res_bump   = 1'b0;
    res_ok     = 1'b0;
    res_fail   = 1'b0;
    case (s2_cls_q)
      CLS_IO: begin
        res_status = ST_IO;
      end
      CLS_UNIMPL: begin
        res_status = ST_UNIMPL;
        res_wide   = s2_wide_q;
      end
      CLS_MEM: begin
        res_size = s2_size_q;
        res_wide = s2_wide_q;
        if (!enable_q) begin
          res_status = ST_EXHAUSTED;
        end else if (fits) begin
          res_status = ST_ASSIGNED;
          res_low    = {start65[WordW-1:4], s2_bar_q[3:0]};
          res_high   = s2_wide_q ? start65[AddrW-1:WordW] : '0;
          res_bump   = 1'b1;
          res_ok     = 1'b1;
        end else begin
          res_status = ST_EXHAUSTED;
          res_fail   = 1'b1;
        end
      end
      default: begin
        res_status = ST_MALFORMED;
      end
    endcase
  end

  // Saturating counters
  logic [CountW-1:0] assigned_q, assigned_d, failed_q, failed_d;

  assign assigned_d = (fire && res_ok && (assigned_q != '1)) ? assigned_q + CountW'(1)
                                                              : assigned_q;
  assign failed_d   = (fire && res_fail && (failed_q != '1)) ? failed_q + CountW'(1)
                                                              : failed_q;

  // -------------------------------------------------------------------------
  // Control state
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      enable_q    <= 1'b0;
      base_q      <= '0;
      size_q      <= '0;
      limit_q     <= '0;
      ptr_q       <= '0;
      assigned_q  <= '0;
      failed_q    <= '0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_adv) begin
        s2_valid_q <= s1_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
      assigned_q <= assigned_d;
      failed_q   <= failed_d;
      // A base write reloads the pointer; otherwise advance past each region.
      if (cfg_wr && (cfg_idx == REG_BASE)) begin
        ptr_q <= pwdata;
      end else if (fire && res_bump) begin
        ptr_q <= end65[AddrW-1:0];
      end
      if (cfg_wr) begin
        case (cfg_idx)
          REG_ENABLE: enable_q <= pwdata[0];
          REG_BASE: begin
            base_q  <= pwdata;
            limit_q <= {1'b0, pwdata} + {1'b0, size_q};
          end
          REG_SIZE: begin
            size_q  <= pwdata;
            limit_q <= {1'b0, base_q} + {1'b0, pwdata};
          end
          default: begin
          end
        endcase
      end
    end
  end

  // -------------------------------------------------------------------------
  // Payload registers
  // -------------------------------------------------------------------------
  status_e           out_status_q;
  logic [WordW-1:0]  out_low_q, out_high_q;
  logic [AddrW-1:0]  out_size_q;
  logic              out_wide_q;
  logic [CountW-1:0] out_assigned_q, out_failed_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_adv) begin
      s1_idx_q <= bar_index_i;
      s1_bar_q <= original_bar_i;
      s1_lo_q  <= probe_low_i;
      s1_hi_q  <= probe_high_i;
    end
    if (s1_valid_q && s2_adv) begin
      s2_cls_q  <= dec_cls;
      s2_wide_q <= dec_is64;
      s2_bar_q  <= s1_bar_q;
      s2_size_q <= dec_size;
      s2_m_q    <= dec_span >> 1;
    end
    if (fire) begin
      out_status_q   <= res_status;
      out_low_q      <= res_low;
      out_high_q     <= res_high;
      out_size_q     <= res_size;
      out_wide_q     <= res_wide;
      out_assigned_q <= assigned_d;
      out_failed_q   <= failed_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign write_low_o      = out_low_q;
  assign write_high_o     = out_high_q;
  assign region_size_o    = out_size_q;
  assign wide_bar_o       = out_wide_q;
  assign assigned_total_o = out_assigned_q;
  assign failed_total_o   = out_failed_q;

endmodule

/* rtl/core/pbsa_checker.sv */
// ---------------------------------------------------------------------------
// PCI BAR sizing and allocation - port checker
// Watches the result channel for stall holding and result consistency.
// ---------------------------------------------------------------------------
`include "pci_bar_size_and_assign_defines.svh"

module pbsa_checker
  import pbsa_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [2:0]       status_o,
  input logic [WordW-1:0] write_low_o,
  input logic [WordW-1:0] write_high_o,
  input logic [AddrW-1:0] region_size_o,
  input logic             wide_bar_o
);

  // Hold a stalled result beat.
  `PBSA_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(write_low_o) && $stable(region_size_o), "stalled result changed")

  // An assigned region has a power-of-two size.
  `PBSA_ASSERT_IMPL(a_assigned_size, out_valid_o && (status_o == ST_ASSIGNED), $onehot(region_size_o), "assigned size not a power of two")

  // I/O and malformed BARs carry no size, no wide flag and no high word.
  `PBSA_ASSERT_IMPL(a_nomem_clean, out_valid_o && ((status_o == ST_IO) || (status_o == ST_MALFORMED)), (region_size_o == '0) && !wide_bar_o && (write_high_o == '0), "io or malformed result carries memory fields")

  // A narrow assigned BAR never gets a high word.
  `PBSA_ASSERT_IMPL(a_narrow_high, out_valid_o && (status_o == ST_ASSIGNED) && !wide_bar_o, write_high_o == '0, "narrow BAR given a high word")

endmodule

bind pci_bar_size_and_assign pbsa_checker u_pbsa_checker (.*);
